// ===== rtl/pmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared geometry, request codes and the command beat passed from the
// front decoder through the command queue to the store sequencer.
// ----------------------------------------------------------------------------
package pmfb_pkg;

  localparam int WIDTH  = 128;
  localparam int PAGES  = 8;
  localparam int ROWS   = PAGES * 8;
  localparam int HALF   = WIDTH / 2;
  localparam int DEPTH  = PAGES * WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [3:0] OP_SET       = 4'd0;
  localparam logic [3:0] OP_CLR       = 4'd1;
  localparam logic [3:0] OP_GET       = 4'd2;
  localparam logic [3:0] OP_VREP      = 4'd3;
  localparam logic [3:0] OP_VOR       = 4'd4;
  localparam logic [3:0] OP_VAND      = 4'd5;
  localparam logic [3:0] OP_HBYTE     = 4'd6;
  localparam logic [3:0] OP_READ      = 4'd7;
  localparam logic [3:0] OP_CLEAR_ALL = 4'd8;

  typedef struct packed {
    logic [3:0]        op;
    logic              ok;
    logic [2:0]        off;
    logic [7:0]        value;
    logic [ADDR_W-1:0] base;
    logic [3:0]        nsteps;
    logic              half;
    logic [5:0]        loc;
  } cmd_t;

endpackage

// ===== rtl/pmfb_front.sv =====
// ----------------------------------------------------------------------------
// pmfb_front
// Classifies one request: bounds, store address, number of read-modify-write
// steps and the controller fields, packed into a command beat.
// ----------------------------------------------------------------------------
module pmfb_front import pmfb_pkg::*; (
  input  logic [3:0] req_type,
  input  logic [9:0] pixel_row,
  input  logic [9:0] pixel_col,
  input  logic [7:0] value,
  output cmd_t       cmd
);

  logic        row_ok;
  logic        col_ok;
  logic        vis;
  logic [6:0]  page;
  logic [20:0] base_full;
  logic        second;
  int          rem;
  logic [3:0]  hb_steps;
  logic        hb_ok;

  always_comb begin
    row_ok    = int'(pixel_row) < ROWS;
    col_ok    = int'(pixel_col) < WIDTH;
    vis       = row_ok && col_ok;
    page      = pixel_row[9:3];
    base_full = 21'(page) * 21'(WIDTH) + 21'(pixel_col);
    second    = (pixel_row[2:0] != 3'd0) && (int'(page) + 1 < PAGES);
    rem       = WIDTH - int'(pixel_col);
    if (!vis) begin
      hb_steps = 4'd0;
    end else if (rem >= 8) begin
      hb_steps = 4'd8;
    end else begin
      hb_steps = 4'(rem);
    end
    hb_ok = row_ok && (int'(pixel_col) + 8 <= WIDTH);
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = req_type;
    cmd.off    = pixel_row[2:0];
    cmd.value  = value;
    cmd.base   = base_full[ADDR_W-1:0];
    case (req_type)
      OP_SET, OP_CLR: begin
        cmd.ok     = vis;
        cmd.nsteps = vis ? 4'd1 : 4'd0;
      end
      OP_GET: begin
        cmd.ok = vis;
      end
      OP_VREP, OP_VOR, OP_VAND: begin
        cmd.ok = vis;
        if (vis) begin
          cmd.nsteps = second ? 4'd2 : 4'd1;
        end
      end
      OP_HBYTE: begin
        cmd.ok     = hb_ok;
        cmd.nsteps = hb_steps;
      end
      OP_READ: begin
        cmd.ok = vis;
        if (vis) begin
          if (int'(pixel_col) >= HALF) begin
            cmd.half = 1'b1;
            cmd.loc  = 6'(int'(pixel_col) - HALF);
          end else begin
            cmd.loc = pixel_col[5:0];
          end
        end
      end
      OP_CLEAR_ALL: begin
        cmd.ok = 1'b1;
      end
      default: begin
        cmd.ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/pmfb_cmdq.sv =====
// ----------------------------------------------------------------------------
// pmfb_cmdq
// Two-entry queue of command beats between the decoder and the sequencer.
// ----------------------------------------------------------------------------
module pmfb_cmdq import pmfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       slots [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign dout    = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/pmfb_back.sv =====
// ----------------------------------------------------------------------------
// pmfb_back
// Store sequencer: owns the frame memory, runs pipelined read-modify-write
// steps, clearing sweeps and reads, and holds the result register.
// ----------------------------------------------------------------------------
module pmfb_back import pmfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cq_dout,
  input  logic       cq_empty,
  output logic       cq_pop,
  output logic       init_busy,
  output logic       res_valid,
  input  logic       pop,
  output logic [7:0] res_data,
  output logic       res_ok,
  output logic       res_half,
  output logic [5:0] res_loc
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [3:0]        idx;
  logic [ADDR_W-1:0] ptr;
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        newb;
  logic              last_step;
  logic              slot_free;
  logic              load;
  logic              is_write;
  logic [7:0]        res_data_next;

  function automatic logic [ADDR_W-1:0] step_addr(cmd_t c, logic [3:0] i);
    logic [ADDR_W-1:0] a;
    case (c.op)
      OP_VREP, OP_VOR, OP_VAND: a = (i == 4'd0) ? c.base : c.base + ADDR_W'(WIDTH);
      OP_HBYTE:                 a = c.base + ADDR_W'(i);
      default:                  a = c.base;
    endcase
    return a;
  endfunction

  // merge of the current step into the byte just read
  always_comb begin
    logic [7:0] bitm;
    logic [3:0] sh;
    logic [7:0] pat;
    logic [7:0] mask;
    bitm = 8'h01 << cmd.off;
    sh   = 4'd8 - {1'b0, cmd.off};
    if (idx == 4'd0) begin
      pat  = cmd.value << cmd.off;
      mask = 8'hFF << cmd.off;
    end else begin
      pat  = cmd.value >> sh;
      mask = 8'hFF >> sh;
    end
    case (cmd.op)
      OP_SET:   newb = rdata | bitm;
      OP_CLR:   newb = rdata & ~bitm;
      OP_VREP:  newb = (rdata & ~mask) | (pat & mask);
      OP_VOR:   newb = rdata | (pat & mask);
      OP_VAND:  newb = rdata & (~mask | (pat & mask));
      OP_HBYTE: newb = cmd.value[3'd7 - idx[2:0]] ? (rdata | bitm) : (rdata & ~bitm);
      default:  newb = rdata;
    endcase
  end

  always_comb begin
    case (cq_dout.op)
      OP_SET, OP_CLR, OP_VREP, OP_VOR, OP_VAND, OP_HBYTE: is_write = 1'b1;
      default:                                            is_write = 1'b0;
    endcase
  end

  assign last_step = (idx == cmd.nsteps - 4'd1);
  assign slot_free = !res_valid || pop;
  assign load      = slot_free && ((state == S_DONE) || (state == S_RMW && last_step));
  assign cq_pop    = (state == S_IDLE) && !cq_empty;
  assign init_busy = (state == S_INIT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = 8'h00;
    mem_raddr = cmd.base;
    case (state)
      S_INIT, S_CLR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = cq_dout.base;
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = step_addr(cmd, idx);
        mem_wdata = newb;
        mem_raddr = step_addr(cmd, 4'(idx + 4'd1));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    case (cmd.op)
      OP_GET:  res_data_next = cmd.ok ? {7'd0, rdata[cmd.off]} : 8'h00;
      OP_READ: res_data_next = cmd.ok ? rdata : 8'h00;
      default: res_data_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr   <= '0;
      idx   <= 4'd0;
    end else begin
      case (state)
        S_INIT, S_CLR: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == ADDR_W'(DEPTH - 1)) begin
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (cq_pop) begin
            idx <= 4'd0;
            ptr <= '0;
            if (cq_dout.op == OP_CLEAR_ALL) begin
              state <= S_CLR;
            end else if (is_write && cq_dout.nsteps != 4'd0) begin
              state <= S_RMW;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RMW: begin
          if (last_step) begin
            state <= slot_free ? S_IDLE : S_DONE;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd <= cq_dout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= res_data_next;
      res_ok   <= cmd.ok;
      res_half <= cmd.half;
      res_loc  <= cmd.loc;
    end
  end

`ifndef SYNTH
  a_no_take_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !cq_pop)
    else $error("command taken during power-up clearing");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW) |-> (idx < cmd.nsteps))
    else $error("step index past step count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!res_valid || pop))
    else $error("result overwrites an untaken result");

  a_clr_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |=> (state == S_CLR || state == S_DONE))
    else $error("clearing sweep left without reporting");
`endif

endmodule

// ===== rtl/paged_mono_framebuffer_engine.sv =====
// Flow: requests wait in the two-entry command queue; the sequencer takes one at a time.
// Writes run one memory read-modify-write step per byte touched: one for a single-byte request,
//   two for a byte split over two pages, one per column for a horizontal run; clear all sweeps
//   every byte through the single memory write port. The queue takes requests while it has room.
// Reset: synchronous; afterward full stays high during a clearing pass that writes every byte of the store.
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_engine
// Page-organized one-bit framebuffer with pixel, vertical byte, horizontal
// run, byte read and clear-all requests, queue handshake on both sides.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_engine import pmfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [3:0] req_type,
  input  logic [9:0] pixel_row,
  input  logic [9:0] pixel_col,
  input  logic [7:0] value,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data,
  output logic       in_range,
  output logic       controller_half,
  output logic [5:0] local_column
);

  // decoded request beat entering the command queue
  cmd_t front_cmd;
  cmd_t cq_dout;
  logic cq_full;
  logic cq_empty;
  logic cq_pop;
  logic init_busy;
  logic res_valid;

  // Classify the request combinationally; the queue holds the decoded beat.
  pmfb_front u_front (
    .req_type  (req_type),
    .pixel_row (pixel_row),
    .pixel_col (pixel_col),
    .value     (value),
    .cmd       (front_cmd)
  );

  // Hold off requests while the queue is full or the power-up clear runs.
  assign full = cq_full || init_busy;

  pmfb_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .din   (front_cmd),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  // Sequencer: memory steps and result register; the queue keeps accepting
  // while a finished result waits to be popped.
  pmfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cq_dout   (cq_dout),
    .cq_empty  (cq_empty),
    .cq_pop    (cq_pop),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .pop       (pop),
    .res_data  (read_data),
    .res_ok    (in_range),
    .res_half  (controller_half),
    .res_loc   (local_column)
  );

  assign empty = !res_valid;

endmodule

// ===== dv/pmfb_checker.sv =====
// ----------------------------------------------------------------------------
// pmfb_checker
// Watches the request and result queues of the framebuffer engine. It keeps
// a shadow copy of the frame store, predicts the reply to each accepted
// request beat and compares every accepted result beat against the oldest
// predicted reply.
// ----------------------------------------------------------------------------
module pmfb_checker import pmfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [3:0] req_type,
  input  logic [9:0] pixel_row,
  input  logic [9:0] pixel_col,
  input  logic [7:0] value,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] read_data,
  input  logic       in_range,
  input  logic       controller_half,
  input  logic [5:0] local_column,
  output int         replies,
  output int         mismatches
);

  typedef struct packed {
    logic [7:0] data;
    logic       ok;
    logic       half;
    logic [5:0] col;
  } reply_t;

  logic [7:0] shadow_frame [DEPTH];
  reply_t     expected_replies [$];

  initial begin
    replies    = 0;
    mismatches = 0;
  end

  function automatic void paint_pixel(input int row, input int col, input logic on);
    shadow_frame[(row >> 3) * WIDTH + col][row & 7] = on;
  endfunction

  function automatic logic [7:0] merge_byte(input logic [7:0] old, input logic [7:0] bits,
                                            input logic [7:0] mask, input logic [3:0] op);
    case (op)
      OP_VREP: return (old & ~mask) | (bits & mask);
      OP_VOR:  return old | (bits & mask);
      default: return old & (~mask | (bits & mask));
    endcase
  endfunction

  // Apply one request to the shadow frame and return the reply it earns.
  function automatic reply_t predict_reply(input logic [3:0] op, input logic [9:0] row,
                                           input logic [9:0] col, input logic [7:0] pat);
    reply_t rep;
    int     page;
    int     off;
    int     idx;
    logic   vis;
    rep  = '0;
    vis  = (row < ROWS) && (col < WIDTH);
    page = int'(row) >> 3;
    off  = int'(row) & 7;
    idx  = page * WIDTH + int'(col);
    case (op)
      OP_SET, OP_CLR: begin
        if (vis) begin
          paint_pixel(int'(row), int'(col), op == OP_SET);
          rep.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (vis) begin
          rep.data = {7'd0, shadow_frame[idx][off]};
          rep.ok   = 1'b1;
        end
      end
      OP_VREP, OP_VOR, OP_VAND: begin
        if (vis) begin
          shadow_frame[idx] = merge_byte(shadow_frame[idx], pat << off, 8'hFF << off, op);
          // spill into the next page only when the strip straddles a page edge
          if (off != 0 && page + 1 < PAGES)
            shadow_frame[idx + WIDTH] = merge_byte(shadow_frame[idx + WIDTH],
                                                   pat >> (8 - off), 8'hFF >> (8 - off), op);
          rep.ok = 1'b1;
        end
      end
      OP_HBYTE: begin
        rep.ok = 1'b1;
        for (int n = 0; n < 8; n++) begin
          if (row < ROWS && int'(col) + n < WIDTH)
            paint_pixel(int'(row), int'(col) + n, pat[7 - n]);
          else
            rep.ok = 1'b0;
        end
      end
      OP_READ: begin
        if (vis) begin
          rep.data = shadow_frame[idx];
          rep.ok   = 1'b1;
          if (col >= HALF) begin
            rep.half = 1'b1;
            rep.col  = 6'(col - HALF);
          end else begin
            rep.col = col[5:0];
          end
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < DEPTH; i++)
          shadow_frame[i] = 8'h00;
        rep.ok = 1'b1;
      end
      default: ;
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++)
        shadow_frame[i] = 8'h00;
      expected_replies.delete();
    end else begin
      if (pop && !empty) begin
        replies <= replies + 1;
        if (expected_replies.size() == 0) begin
          $error("result beat with no reply expected");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (read_data !== want.data) begin
            $error("read_data: expected %0h, got %0h", want.data, read_data);
            mismatches++;
          end
          if (in_range !== want.ok) begin
            $error("in_range: expected %0b, got %0b", want.ok, in_range);
            mismatches++;
          end
          if (controller_half !== want.half) begin
            $error("controller_half: expected %0b, got %0b", want.half, controller_half);
            mismatches++;
          end
          if (local_column !== want.col) begin
            $error("local_column: expected %0d, got %0d", want.col, local_column);
            mismatches++;
          end
        end
      end
      if (push && !full)
        expected_replies.push_back(predict_reply(req_type, pixel_row, pixel_col, value));
    end
  end

endmodule

// ===== dv/paged_mono_framebuffer_engine_tb.sv =====
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_engine_tb
// Drives pixel, byte, run, read and clear-all requests into the framebuffer
// engine: a directed pass over the screen edges and special requests, then
// random traffic in phases with different amounts of sender idling and
// receiver stalling, one long receiver hold-off and drain pauses. A checker
// beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_engine_tb;
  import pmfb_pkg::*;

  // request codes the block ignores
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [3:0] req_type = '0;
  logic [9:0] pixel_row = '0;
  logic [9:0] pixel_col = '0;
  logic [7:0] value = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_data;
  logic       in_range;
  logic       controller_half;
  logic [5:0] local_column;

  int     replies;
  int     mismatches;
  int     items_sent = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  phase_t phase = PH_FREE;
  int     cycle_count = 0;

  paged_mono_framebuffer_engine dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .pixel_row       (pixel_row),
    .pixel_col       (pixel_col),
    .value           (value),
    .empty           (empty),
    .pop             (pop),
    .read_data       (read_data),
    .in_range        (in_range),
    .controller_half (controller_half),
    .local_column    (local_column)
  );

  pmfb_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .pixel_row       (pixel_row),
    .pixel_col       (pixel_col),
    .value           (value),
    .empty           (empty),
    .pop             (pop),
    .read_data       (read_data),
    .in_range        (in_range),
    .controller_half (controller_half),
    .local_column    (local_column),
    .replies         (replies),
    .mismatches      (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost reply ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("paged_mono_framebuffer_engine_tb: done, errors");
    $finish;
  end

  // Result side. Stall at the phase's rate; on entering the hold phase, hold
  // pop low for a long stretch so the block backs up and raises full.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_HOLD && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request beat, idling first at the current rate. Leave push high
  // after the accept; the next call or the caller decides what follows.
  task automatic send_req(input logic [3:0] op, input int row,
                          input int col, input logic [7:0] pat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    req_type  <= op;
    pixel_row <= 10'(row);
    pixel_col <= 10'(col);
    value     <= pat;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Drop push and hold off until every reply sent so far has come back.
  task automatic drain;
    push <= 1'b0;
    while (replies < items_sent) @(posedge clk);
  endtask

  initial begin
    logic [3:0] op;
    logic [9:0] row;
    logic [9:0] col;
    int         pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed pass: screen corners, off-screen coordinates, byte strips that
    // sit on a page boundary or straddle one, a strip on the last page, runs
    // that fit or fall off the right edge, both controller halves, clear all
    // and the ignored request codes.
    send_req(OP_SET,       0,        0,         8'h00);
    send_req(OP_SET,       ROWS - 1, WIDTH - 1, 8'h00);
    send_req(OP_GET,       0,        0,         8'h00);
    send_req(OP_GET,       ROWS - 1, WIDTH - 1, 8'h00);
    send_req(OP_CLR,       0,        0,         8'h00);
    send_req(OP_GET,       0,        0,         8'h00);
    send_req(OP_SET,       ROWS,     0,         8'h00);
    send_req(OP_GET,       0,        WIDTH,     8'h00);
    send_req(OP_VREP,      8,        5,         8'hFF);
    send_req(OP_VOR,       13,       5,         8'hA5);
    send_req(OP_VAND,      11,       5,         8'h00);
    send_req(OP_READ,      8,        5,         8'h00);
    send_req(OP_READ,      16,       5,         8'h00);
    send_req(OP_VREP,      ROWS - 3, 20,        8'hFF);
    send_req(OP_HBYTE,     3,        WIDTH - 8, 8'hB6);
    send_req(OP_HBYTE,     4,        WIDTH - 3, 8'hFF);
    send_req(OP_READ,      0,        HALF - 1,  8'h00);
    send_req(OP_READ,      ROWS - 1, HALF,      8'h00);
    send_req(OP_READ,      0,        WIDTH - 1, 8'h00);
    send_req(OP_READ,      1023,     1023,      8'h00);
    send_req(OP_CLEAR_ALL, 0,        0,         8'h00);
    send_req(OP_READ,      ROWS - 1, WIDTH - 1, 8'h00);
    send_req(OP_HBYTE,     ROWS,     0,         8'hFF);
    send_req(OP_UNUSED_LO, 0,        0,         8'h00);
    send_req(OP_UNUSED_HI, 1023,     1023,      8'hFF);
    drain();

    // Random traffic, one phase per idling pattern. Half the requests land in
    // a small corner window so reads keep hitting bytes written earlier.
    for (int p = PH_FREE; p <= PH_HOLD; p++) begin
      case (phase_t'(p))
        PH_SEND_IDLE:  begin send_idle_pct = 68; recv_stall_pct <= 0;  end
        PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
        PH_BOTH:       begin send_idle_pct = 22; recv_stall_pct <= 22; end
        default:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      endcase
      phase <= phase_t'(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)
          op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (pick < 4)
          op = OP_CLEAR_ALL;
        else
          op = 4'($urandom_range(OP_SET, OP_READ));

        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          row = 10'($urandom_range(0, 15));
          col = 10'($urandom_range(0, 15));
        end else if (pick < 88) begin
          row = 10'($urandom_range(0, ROWS - 1));
          col = 10'($urandom_range(0, WIDTH - 1));
        end else if (pick < 94) begin
          // crowd the right edge so runs get clipped
          row = 10'($urandom_range(0, ROWS - 1));
          col = 10'($urandom_range(WIDTH - 8, WIDTH - 1));
        end else begin
          row = 10'($urandom_range(0, 1023));
          col = 10'($urandom_range(0, 1023));
        end
        send_req(op, int'(row), int'(col), 8'($urandom_range(0, 255)));
      end
      drain();
    end

    // Let any stray beat show up, then give the verdict.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    phase <= PH_FREE;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies == items_sent)
      $display("paged_mono_framebuffer_engine_tb: done, clean");
    else
      $display("paged_mono_framebuffer_engine_tb: done, errors");
    $finish;
  end

endmodule
